[hdl/bds_pkg.sv]
// Shared types, widths and constants of the bilinear density sampler.
`default_nettype none
package bds_pkg;

	// Sizing of the stores and of the arithmetic
	localparam int GRID_ROOT     = 128;
	localparam int GAMMA_ENTRIES = 1024;
	localparam int DENSITY_BITS  = 16;
	localparam int COORD_BITS    = 12;

	// Fixed port widths
	localparam int CMD_W        = 2;
	localparam int CELL_PORT_W  = 8;
	localparam int VALUE_PORT_W = 16;
	localparam int PIXEL_PORT_W = 12;
	localparam int GIDX_PORT_W  = 10;
	localparam int LEVEL_W      = 8;
	localparam int RGB_W        = 3 * LEVEL_W;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 24;
	localparam int SCALE_W      = 24;

	// Coordinate mapping
	localparam int FRAC_W  = 16;
	localparam int WGT_W   = FRAC_W + 1;
	localparam int POS_W   = COORD_BITS + SCALE_W;
	localparam int IPART_W = POS_W - FRAC_W;

	// Grid geometry, split into four banks by column and row parity
	localparam int GRID_SIDE  = GRID_ROOT + 2;
	localparam int CELL_W     = $clog2(GRID_SIDE);
	localparam int HALF_SIDE  = (GRID_SIDE + 1) / 2;
	localparam int BANK_DEPTH = HALF_SIDE * HALF_SIDE;
	localparam int BANK_AW    = $clog2(BANK_DEPTH);
	localparam int NUM_BANKS  = 4;
	localparam int WORD_W     = 3 * DENSITY_BITS;

	// Blend widths: both blend steps are convex, so no headroom is needed
	localparam int TOP_W   = DENSITY_BITS + FRAC_W;
	localparam int BLEND_W = DENSITY_BITS + 2 * FRAC_W;
	localparam int UW      = BLEND_W - 1;
	localparam int GAW     = $clog2(GAMMA_ENTRIES);

	localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1) << FRAC_W;
	localparam logic [WGT_W-1:0]   WGT_ONE     = {1'b1, {FRAC_W{1'b0}}};
	localparam logic [CELL_W-1:0]  ROOT_CELL   = CELL_W'(GRID_ROOT);
	localparam logic [IPART_W-1:0] IPART_ROOT  = IPART_W'(GRID_ROOT);
	localparam logic [UW-1:0]      BLEND_ONE   = {1'b1, {(UW - 1){1'b0}}};
	localparam logic [GAW-1:0]     GAMMA_MAX   = GAW'(GAMMA_ENTRIES - 1);

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE_CELL  = 2'd0,
		CMD_SAMPLE      = 2'd1,
		CMD_WRITE_GAMMA = 2'd2
	} bds_cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_X_SCALE = 2'd0,
		CFG_Y_SCALE = 2'd1
	} bds_cfg_t;

	// Gamma write carried down to the gamma read stage
	typedef struct packed {
		logic                ok;
		logic [GAW-1:0]      idx;
		logic [LEVEL_W-1:0]  data;
	} bds_gwr_t;

	typedef struct packed {
		bds_cmd_t cmd;
		bds_gwr_t gwr;
	} bds_tag_t;

	// Stage advance strobes handed to the blend lanes
	typedef struct packed {
		logic s8;
		logic s7;
		logic s6;
		logic s5;
		logic s4;
	} bds_adv_t;

endpackage
`default_nettype wire

[hdl/bilinear_density_sampler_gamma.sv]
// Top level of the bilinear density sampler with gamma lookup.
`default_nettype none
// Usage:
//   Items arrive on in_valid/in_ready with the command and its fields. A write
//   cell item loads one grid cell (red, green, blue at once), a write gamma item
//   loads one byte of the gamma table; neither gives a result. A sample item
//   maps pixel_x/pixel_y through x_scale/y_scale, blends the four neighbouring
//   cells per channel, clamps to [0,1], looks the level up in the gamma table
//   and returns one item on out_valid/out_ready carrying pixel_rgb.
//   Throughput is one item per clock while the receiver takes results. The four
//   neighbours come from four grid banks split by column and row parity, one
//   read port each, and the gamma table is held in three copies, one per
//   channel, so no item waits on a port. A sample passes the scale, split, bank
//   read, blend and gamma stages in turn. Items stay in order; a write lands
//   before any later sample reads.
//   The user writes configuration through cfg_we/cfg_index/cfg_data while
//   the block is idle; the block does not enforce this. Reset clears the
//   pipeline valid bits and sets both scales to 1.0; grid and gamma contents
//   are undefined until written. When the receiver stalls, the result holds
//   on pixel_rgb and items behind it keep moving up into empty stages; in_ready
//   drops only once stage one is full and cannot advance.
module bilinear_density_sampler_gamma (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     cfg_we,
	input  wire logic        [bds_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic        [bds_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                                     in_valid,
	output logic                                          in_ready,
	input  wire logic        [bds_pkg::CMD_W-1:0]         command,
	input  wire logic        [bds_pkg::CELL_PORT_W-1:0]   cell_x,
	input  wire logic        [bds_pkg::CELL_PORT_W-1:0]   cell_y,
	input  wire logic signed [bds_pkg::VALUE_PORT_W-1:0]  red_value,
	input  wire logic signed [bds_pkg::VALUE_PORT_W-1:0]  green_value,
	input  wire logic signed [bds_pkg::VALUE_PORT_W-1:0]  blue_value,
	input  wire logic        [bds_pkg::PIXEL_PORT_W-1:0]  pixel_x,
	input  wire logic        [bds_pkg::PIXEL_PORT_W-1:0]  pixel_y,
	input  wire logic        [bds_pkg::GIDX_PORT_W-1:0]   gamma_index,
	input  wire logic        [bds_pkg::LEVEL_W-1:0]       gamma_byte,
	output logic                                          out_valid,
	input  wire logic                                     out_ready,
	output logic             [bds_pkg::RGB_W-1:0]         pixel_rgb
);

	// Configuration registers
	logic [bds_pkg::SCALE_W-1:0] x_scale_q, y_scale_q;

	// Stage occupancy (stages 1 to 9) and advance strobes
	logic [9:1] valid_q;
	logic [9:1] advance;

	// Stage 1: products and write payloads
	bds_pkg::bds_tag_t tag_in;
	logic [bds_pkg::COORD_BITS-1:0] pix_x, pix_y;
	logic [bds_pkg::POS_W-1:0] pos_x, pos_y;
	logic cell_ok_in;
	logic [bds_pkg::WORD_W-1:0] word_in;

	bds_pkg::bds_tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7, tag_s8;
	logic [bds_pkg::POS_W-1:0] pos_x_s1, pos_y_s1;
	logic [bds_pkg::CELL_W-1:0] cell_x_s1, cell_y_s1;
	logic cell_ok_s1;
	logic [bds_pkg::WORD_W-1:0] word_s1;

	// Stage 2: cell coordinates and weights
	logic [bds_pkg::IPART_W-1:0] ip_x, ip_y;
	logic [bds_pkg::CELL_W-1:0] map_x, map_y;
	logic [bds_pkg::WGT_W-1:0] map_fx, map_fy;
	logic [bds_pkg::CELL_W-1:0] x0_s2, y0_s2;
	logic [bds_pkg::WGT_W-1:0] fx_s2, fy_s2;
	logic cell_ok_s2;
	logic [bds_pkg::WORD_W-1:0] word_s2;

	// Grid banks
	logic [bds_pkg::CELL_W-1:0] col_even, col_odd, row_even, row_odd;
	logic [1:0] write_bank;
	logic [bds_pkg::BANK_AW-1:0] bank_addr [bds_pkg::NUM_BANKS];
	logic [bds_pkg::NUM_BANKS-1:0] bank_we;
	logic [bds_pkg::WORD_W-1:0] bank_word_s3 [bds_pkg::NUM_BANKS];

	// Stage 3 onward
	logic xp_s3, yp_s3;
	logic [bds_pkg::WGT_W-1:0] wx0_s3, wx1_s3, wy0_s3, wy1_s3;
	logic [bds_pkg::WGT_W-1:0] wy0_s4, wy1_s4, wy0_s5, wy1_s5;
	logic [bds_pkg::WORD_W-1:0] w00, w10, w01, w11;
	bds_pkg::bds_adv_t lane_adv;
	logic [bds_pkg::GAW-1:0] gamma_addr [3];
	logic gamma_we;
	logic [bds_pkg::LEVEL_W-1:0] level_s9 [3];

	// ---------------------------------------------------------------
	// Configuration
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_scale_q <= bds_pkg::SCALE_RESET;
			y_scale_q <= bds_pkg::SCALE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bds_pkg::CFG_X_SCALE: x_scale_q <= cfg_data;
				bds_pkg::CFG_Y_SCALE: y_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Flow control: a stage advances when it is empty or the next one
	// advances; the last stage is the output register.
	// ---------------------------------------------------------------
	always_comb begin
		advance[9] = !valid_q[9] || out_ready;
		for (int k = 8; k >= 1; k--) begin
			advance[k] = !valid_q[k] || advance[k + 1];
		end
	end

	assign in_ready  = advance[1];
	assign out_valid = valid_q[9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (advance[1]) begin
				valid_q[1] <= in_valid;
			end
			for (int k = 2; k <= 8; k++) begin
				if (advance[k]) begin
					valid_q[k] <= valid_q[k - 1];
				end
			end
			// drop items that give no result on entry to the output register
			if (advance[9]) begin
				valid_q[9] <= valid_q[8] && (tag_s8.cmd == bds_pkg::CMD_SAMPLE);
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: scale the pixel into Q.16 grid coordinates
	// ---------------------------------------------------------------
	assign pix_x = bds_pkg::COORD_BITS'(pixel_x);
	assign pix_y = bds_pkg::COORD_BITS'(pixel_y);
	assign pos_x = bds_pkg::POS_W'(pix_x) * bds_pkg::POS_W'(x_scale_q);
	assign pos_y = bds_pkg::POS_W'(pix_y) * bds_pkg::POS_W'(y_scale_q);

	always_comb begin
		tag_in.cmd      = bds_pkg::bds_cmd_t'(command);
		tag_in.gwr.ok   = 32'(gamma_index) < 32'(bds_pkg::GAMMA_ENTRIES);
		tag_in.gwr.idx  = bds_pkg::GAW'(gamma_index);
		tag_in.gwr.data = gamma_byte;
		cell_ok_in      = (32'(cell_x) < 32'(bds_pkg::GRID_SIDE))
			&& (32'(cell_y) < 32'(bds_pkg::GRID_SIDE));
		word_in         = {bds_pkg::DENSITY_BITS'($unsigned(red_value)),
			bds_pkg::DENSITY_BITS'($unsigned(green_value)),
			bds_pkg::DENSITY_BITS'($unsigned(blue_value))};
	end

	// ---------------------------------------------------------------
	// Stage 2: split into cell and weight, saturate past the grid edge
	// ---------------------------------------------------------------
	always_comb begin
		ip_x = pos_x_s1[bds_pkg::POS_W-1:bds_pkg::FRAC_W];
		ip_y = pos_y_s1[bds_pkg::POS_W-1:bds_pkg::FRAC_W];
		if (ip_x > bds_pkg::IPART_ROOT) begin
			map_x  = bds_pkg::ROOT_CELL;
			map_fx = bds_pkg::WGT_ONE;
		end else begin
			map_x  = bds_pkg::CELL_W'(ip_x);
			map_fx = {1'b0, pos_x_s1[bds_pkg::FRAC_W-1:0]};
		end
		if (ip_y > bds_pkg::IPART_ROOT) begin
			map_y  = bds_pkg::ROOT_CELL;
			map_fy = bds_pkg::WGT_ONE;
		end else begin
			map_y  = bds_pkg::CELL_W'(ip_y);
			map_fy = {1'b0, pos_y_s1[bds_pkg::FRAC_W-1:0]};
		end
	end

	// ---------------------------------------------------------------
	// Grid bank addressing. Bank {row parity, column parity} holds the
	// cells of that parity; each of the four neighbours hits its own bank.
	// A cell write uses the same address in the bank of its own parity.
	// ---------------------------------------------------------------
	always_comb begin
		col_odd    = x0_s2 >> 1;
		col_even   = (x0_s2 >> 1) + bds_pkg::CELL_W'(x0_s2[0]);
		row_odd    = y0_s2 >> 1;
		row_even   = (y0_s2 >> 1) + bds_pkg::CELL_W'(y0_s2[0]);
		write_bank = {y0_s2[0], x0_s2[0]};
		for (int b = 0; b < bds_pkg::NUM_BANKS; b++) begin
			bank_addr[b] = bds_pkg::BANK_AW'(b[1] ? row_odd : row_even)
				* bds_pkg::BANK_AW'(bds_pkg::HALF_SIDE)
				+ bds_pkg::BANK_AW'(b[0] ? col_odd : col_even);
			bank_we[b] = advance[3] && valid_q[2]
				&& (tag_s2.cmd == bds_pkg::CMD_WRITE_CELL) && cell_ok_s2
				&& (write_bank == 2'(b));
		end
	end

	for (genvar b = 0; b < bds_pkg::NUM_BANKS; b++) begin : g_bank
		bds_ram #(
			.WIDTH(bds_pkg::WORD_W),
			.DEPTH(bds_pkg::BANK_DEPTH)
		) u_bank (
			.clk   (clk),
			.we    (bank_we[b]),
			.waddr (bank_addr[b]),
			.wdata (word_s2),
			.re    (advance[3]),
			.raddr (bank_addr[b]),
			.rdata (bank_word_s3[b])
		);
	end

	// ---------------------------------------------------------------
	// Payload registers of stages 1 to 8
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (advance[1]) begin
			tag_s1     <= tag_in;
			pos_x_s1   <= pos_x;
			pos_y_s1   <= pos_y;
			cell_x_s1  <= bds_pkg::CELL_W'(cell_x);
			cell_y_s1  <= bds_pkg::CELL_W'(cell_y);
			cell_ok_s1 <= cell_ok_in;
			word_s1    <= word_in;
		end
		if (advance[2]) begin
			tag_s2     <= tag_s1;
			// a cell write carries its own cell in the coordinate registers
			x0_s2      <= (tag_s1.cmd == bds_pkg::CMD_WRITE_CELL) ? cell_x_s1 : map_x;
			y0_s2      <= (tag_s1.cmd == bds_pkg::CMD_WRITE_CELL) ? cell_y_s1 : map_y;
			fx_s2      <= map_fx;
			fy_s2      <= map_fy;
			cell_ok_s2 <= cell_ok_s1;
			word_s2    <= word_s1;
		end
		if (advance[3]) begin
			tag_s3 <= tag_s2;
			xp_s3  <= x0_s2[0];
			yp_s3  <= y0_s2[0];
			wx0_s3 <= bds_pkg::WGT_ONE - fx_s2;
			wx1_s3 <= fx_s2;
			wy0_s3 <= bds_pkg::WGT_ONE - fy_s2;
			wy1_s3 <= fy_s2;
		end
		if (advance[4]) begin
			tag_s4 <= tag_s3;
			wy0_s4 <= wy0_s3;
			wy1_s4 <= wy1_s3;
		end
		if (advance[5]) begin
			tag_s5 <= tag_s4;
			wy0_s5 <= wy0_s4;
			wy1_s5 <= wy1_s4;
		end
		if (advance[6]) begin
			tag_s6 <= tag_s5;
		end
		if (advance[7]) begin
			tag_s7 <= tag_s6;
		end
		if (advance[8]) begin
			tag_s8 <= tag_s7;
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: route the bank words to the four neighbours
	// ---------------------------------------------------------------
	assign w00 = bank_word_s3[{yp_s3, xp_s3}];
	assign w10 = bank_word_s3[{yp_s3, !xp_s3}];
	assign w01 = bank_word_s3[{!yp_s3, xp_s3}];
	assign w11 = bank_word_s3[{!yp_s3, !xp_s3}];

	always_comb begin
		lane_adv.s4 = advance[4];
		lane_adv.s5 = advance[5];
		lane_adv.s6 = advance[6];
		lane_adv.s7 = advance[7];
		lane_adv.s8 = advance[8];
	end

	// ---------------------------------------------------------------
	// Stages 4 to 8: one blend lane per channel, red first
	// ---------------------------------------------------------------
	for (genvar c = 0; c < 3; c++) begin : g_lane
		bds_lane u_lane (
			.clk  (clk),
			.adv  (lane_adv),
			.d00  ($signed(w00[(2 - c) * bds_pkg::DENSITY_BITS +: bds_pkg::DENSITY_BITS])),
			.d10  ($signed(w10[(2 - c) * bds_pkg::DENSITY_BITS +: bds_pkg::DENSITY_BITS])),
			.d01  ($signed(w01[(2 - c) * bds_pkg::DENSITY_BITS +: bds_pkg::DENSITY_BITS])),
			.d11  ($signed(w11[(2 - c) * bds_pkg::DENSITY_BITS +: bds_pkg::DENSITY_BITS])),
			.wx0  (wx0_s3),
			.wx1  (wx1_s3),
			.wy0  (wy0_s5),
			.wy1  (wy1_s5),
			.gidx (gamma_addr[c])
		);
	end

	// ---------------------------------------------------------------
	// Stage 9: gamma lookup; the table copies' read registers are the
	// output register and hold while the receiver stalls.
	// ---------------------------------------------------------------
	assign gamma_we = advance[9] && valid_q[8]
		&& (tag_s8.cmd == bds_pkg::CMD_WRITE_GAMMA) && tag_s8.gwr.ok;

	for (genvar c = 0; c < 3; c++) begin : g_gamma
		bds_ram #(
			.WIDTH(bds_pkg::LEVEL_W),
			.DEPTH(bds_pkg::GAMMA_ENTRIES)
		) u_gamma (
			.clk   (clk),
			.we    (gamma_we),
			.waddr (tag_s8.gwr.idx),
			.wdata (tag_s8.gwr.data),
			.re    (advance[9]),
			.raddr (gamma_addr[c]),
			.rdata (level_s9[c])
		);
	end

	assign pixel_rgb = {level_s9[0], level_s9[1], level_s9[2]};

endmodule
`default_nettype wire

[hdl/bds_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module bds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[hdl/bds_lane.sv]
// One colour channel of the blend: weights, bilinear sum, clamp and gamma index.
`default_nettype none
module bds_lane (
	input  wire logic                                   clk,
	input  wire bds_pkg::bds_adv_t                      adv,
	input  wire logic signed [bds_pkg::DENSITY_BITS-1:0] d00,
	input  wire logic signed [bds_pkg::DENSITY_BITS-1:0] d10,
	input  wire logic signed [bds_pkg::DENSITY_BITS-1:0] d01,
	input  wire logic signed [bds_pkg::DENSITY_BITS-1:0] d11,
	input  wire logic        [bds_pkg::WGT_W-1:0]        wx0,
	input  wire logic        [bds_pkg::WGT_W-1:0]        wx1,
	input  wire logic        [bds_pkg::WGT_W-1:0]        wy0,
	input  wire logic        [bds_pkg::WGT_W-1:0]        wy1,
	output logic             [bds_pkg::GAW-1:0]          gidx
);

	logic signed [bds_pkg::DENSITY_BITS+bds_pkg::WGT_W:0] m00, m10, m01, m11;
	logic signed [bds_pkg::TOP_W-1:0] p00_s4, p10_s4, p01_s4, p11_s4;
	logic signed [bds_pkg::TOP_W-1:0] top_s5, bot_s5;
	logic signed [bds_pkg::TOP_W+bds_pkg::WGT_W:0] n0, n1;
	logic signed [bds_pkg::BLEND_W-1:0] q0_s6, q1_s6, v_s7;
	logic [bds_pkg::UW-1:0] u_s8;
	logic [bds_pkg::UW+bds_pkg::GAW-1:0] scaled;

	assign m00 = d00 * $signed({1'b0, wx0});
	assign m10 = d10 * $signed({1'b0, wx1});
	assign m01 = d01 * $signed({1'b0, wx0});
	assign m11 = d11 * $signed({1'b0, wx1});

	assign n0 = top_s5 * $signed({1'b0, wy0});
	assign n1 = bot_s5 * $signed({1'b0, wy1});

	// index = floor(u * (entries - 1)) with u in Q.(UW-1)
	assign scaled = u_s8 * bds_pkg::GAMMA_MAX;
	assign gidx   = scaled[bds_pkg::UW-1 +: bds_pkg::GAW];

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			p00_s4 <= m00[bds_pkg::TOP_W-1:0];
			p10_s4 <= m10[bds_pkg::TOP_W-1:0];
			p01_s4 <= m01[bds_pkg::TOP_W-1:0];
			p11_s4 <= m11[bds_pkg::TOP_W-1:0];
		end
		if (adv.s5) begin
			top_s5 <= p00_s4 + p10_s4;
			bot_s5 <= p01_s4 + p11_s4;
		end
		if (adv.s6) begin
			q0_s6 <= n0[bds_pkg::BLEND_W-1:0];
			q1_s6 <= n1[bds_pkg::BLEND_W-1:0];
		end
		if (adv.s7) begin
			v_s7 <= q0_s6 + q1_s6;
		end
		if (adv.s8) begin
			// clamp to [0, 1.0]
			priority if (v_s7[bds_pkg::BLEND_W-1]) begin
				u_s8 <= '0;
			end else if (v_s7[bds_pkg::UW-1:0] > bds_pkg::BLEND_ONE) begin
				u_s8 <= bds_pkg::BLEND_ONE;
			end else begin
				u_s8 <= v_s7[bds_pkg::UW-1:0];
			end
		end
	end

endmodule
`default_nettype wire

[verif/tb_bilinear_density_sampler_gamma.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the bilinear density sampler with gamma lookup.
module tb_bilinear_density_sampler_gamma;

	// Codes with no member in the package enums
	localparam logic [bds_pkg::CMD_W-1:0]     CMD_UNUSED   = 2'd3;
	localparam logic [bds_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [bds_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	localparam int GRID_CELLS       = bds_pkg::GRID_SIDE * bds_pkg::GRID_SIDE;
	// Fraction bits of the exact blend: density Q1.14 times two Q1.16 weights
	localparam int BLEND_FRAC       = bds_pkg::DENSITY_BITS - 2 + 2 * bds_pkg::FRAC_W;
	// Long enough for writes still in flight to leave the pipeline
	localparam int SETTLE_CYCLES    = 12;
	localparam int WATCHDOG_LIMIT   = 1000;
	localparam int NUM_PHASES       = 6;
	// Items per random phase, counting the writes that prepare a sample
	localparam int RANDOM_PER_PHASE = 110;

	logic                                       clk;
	logic                                       arst_n;
	logic                                       cfg_we;
	logic        [bds_pkg::CFG_IDX_W-1:0]       cfg_index;
	logic        [bds_pkg::CFG_DATA_W-1:0]      cfg_data;
	logic                                       in_valid;
	logic                                       in_ready;
	logic        [bds_pkg::CMD_W-1:0]           command;
	logic        [bds_pkg::CELL_PORT_W-1:0]     cell_x;
	logic        [bds_pkg::CELL_PORT_W-1:0]     cell_y;
	logic signed [bds_pkg::VALUE_PORT_W-1:0]    red_value;
	logic signed [bds_pkg::VALUE_PORT_W-1:0]    green_value;
	logic signed [bds_pkg::VALUE_PORT_W-1:0]    blue_value;
	logic        [bds_pkg::PIXEL_PORT_W-1:0]    pixel_x;
	logic        [bds_pkg::PIXEL_PORT_W-1:0]    pixel_y;
	logic        [bds_pkg::GIDX_PORT_W-1:0]     gamma_index;
	logic        [bds_pkg::LEVEL_W-1:0]         gamma_byte;
	logic                                       out_valid;
	logic                                       out_ready;
	logic        [bds_pkg::RGB_W-1:0]           pixel_rgb;

	// One item as sent to the block; typed marks a result written into the table
	typedef struct {
		logic        [bds_pkg::CMD_W-1:0]        command;
		logic        [bds_pkg::CELL_PORT_W-1:0]  cell_x;
		logic        [bds_pkg::CELL_PORT_W-1:0]  cell_y;
		logic signed [bds_pkg::VALUE_PORT_W-1:0] red_value;
		logic signed [bds_pkg::VALUE_PORT_W-1:0] green_value;
		logic signed [bds_pkg::VALUE_PORT_W-1:0] blue_value;
		logic        [bds_pkg::PIXEL_PORT_W-1:0] pixel_x;
		logic        [bds_pkg::PIXEL_PORT_W-1:0] pixel_y;
		logic        [bds_pkg::GIDX_PORT_W-1:0]  gamma_index;
		logic        [bds_pkg::LEVEL_W-1:0]      gamma_byte;
		bit                                      typed;
		logic        [bds_pkg::RGB_W-1:0]        rgb;
	} sampler_op_t;

	typedef struct {
		logic signed [bds_pkg::DENSITY_BITS-1:0] red;
		logic signed [bds_pkg::DENSITY_BITS-1:0] green;
		logic signed [bds_pkg::DENSITY_BITS-1:0] blue;
	} cell_t;

	// Mirror of the block's stores and scale registers
	cell_t                       density_grid [GRID_CELLS];
	logic [bds_pkg::LEVEL_W-1:0] level_lut    [bds_pkg::GAMMA_ENTRIES];
	bit                          cell_seen    [GRID_CELLS];
	bit                          level_seen   [bds_pkg::GAMMA_ENTRIES];
	logic [bds_pkg::SCALE_W-1:0] x_scale_now;
	logic [bds_pkg::SCALE_W-1:0] y_scale_now;

	logic [bds_pkg::RGB_W-1:0]   expected_rgb [$];
	int                          rgb_errors   = 0;
	int                          stuck_cycles = 0;
	int                          sent_items   = 0;
	bit                          idle_on      = 1'b1;
	// Table expectation that travels with the item on the input port
	bit                          cur_typed;
	logic [bds_pkg::RGB_W-1:0]   cur_rgb;

	bilinear_density_sampler_gamma DUT (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------

	// Split a pixel into a grid cell and a Q1.16 weight; saturate past the grid
	function automatic void map_axis(input logic [bds_pkg::PIXEL_PORT_W-1:0] pix,
			input logic [bds_pkg::SCALE_W-1:0] scale, output int coord,
			output logic [bds_pkg::WGT_W-1:0] wgt);
		logic [bds_pkg::POS_W-1:0] pos;
		pos = bds_pkg::POS_W'(pix) * bds_pkg::POS_W'(scale);
		if (pos[bds_pkg::POS_W-1:bds_pkg::FRAC_W] > bds_pkg::GRID_ROOT) begin
			coord = bds_pkg::GRID_ROOT;
			wgt   = bds_pkg::WGT_ONE;
		end else begin
			coord = int'(pos[bds_pkg::POS_W-1:bds_pkg::FRAC_W]);
			wgt   = bds_pkg::WGT_W'(pos[bds_pkg::FRAC_W-1:0]);
		end
	endfunction

	// Exact bilinear blend of one channel, clamp to [0,1], then gamma index
	function automatic int blend_index(
			input logic signed [bds_pkg::DENSITY_BITS-1:0] d00, d10, d01, d11,
			input logic [bds_pkg::WGT_W-1:0] wx, wy);
		longint wx1, wx0, wy1, wy0, top, bot, blend, gidx;
		wx1   = longint'(wx);
		wx0   = (longint'(1) <<< bds_pkg::FRAC_W) - wx1;
		wy1   = longint'(wy);
		wy0   = (longint'(1) <<< bds_pkg::FRAC_W) - wy1;
		top   = longint'(d00) * wx0 + longint'(d10) * wx1;
		bot   = longint'(d01) * wx0 + longint'(d11) * wx1;
		blend = top * wy0 + bot * wy1;
		if (blend < 0)
			blend = 0;
		if (blend > (longint'(1) <<< BLEND_FRAC))
			blend = longint'(1) <<< BLEND_FRAC;
		// floor(blend * (entries-1)) with blend taken as a fraction of one
		gidx = (blend * (bds_pkg::GAMMA_ENTRIES - 1)) >>> BLEND_FRAC;
		if (gidx > bds_pkg::GAMMA_ENTRIES - 1)
			gidx = bds_pkg::GAMMA_ENTRIES - 1;
		return int'(gidx);
	endfunction

	// Gamma entries read by the three channels of a sample, red first
	function automatic void sample_indexes(input logic [bds_pkg::PIXEL_PORT_W-1:0] px, py,
			output int ri, gi, bi);
		int                        x0, y0, i00;
		logic [bds_pkg::WGT_W-1:0] fx, fy;
		cell_t                     c00, c10, c01, c11;
		map_axis(px, x_scale_now, x0, fx);
		map_axis(py, y_scale_now, y0, fy);
		i00 = x0 + bds_pkg::GRID_SIDE * y0;
		c00 = density_grid[i00];
		c10 = density_grid[i00 + 1];
		c01 = density_grid[i00 + bds_pkg::GRID_SIDE];
		c11 = density_grid[i00 + bds_pkg::GRID_SIDE + 1];
		ri  = blend_index(c00.red,   c10.red,   c01.red,   c11.red,   fx, fy);
		gi  = blend_index(c00.green, c10.green, c01.green, c11.green, fx, fy);
		bi  = blend_index(c00.blue,  c10.blue,  c01.blue,  c11.blue,  fx, fy);
	endfunction

	function automatic logic [bds_pkg::RGB_W-1:0] predict_rgb(
			input logic [bds_pkg::PIXEL_PORT_W-1:0] px, py);
		int ri, gi, bi;
		sample_indexes(px, py, ri, gi, bi);
		return {level_lut[ri], level_lut[gi], level_lut[bi]};
	endfunction

	// ---------------------------------------------------------------------
	// Item builders: fields a command ignores still carry random bits
	// ---------------------------------------------------------------------

	function automatic sampler_op_t scramble_op();
		sampler_op_t s;
		s.command     = bds_pkg::CMD_W'($urandom);
		s.cell_x      = bds_pkg::CELL_PORT_W'($urandom);
		s.cell_y      = bds_pkg::CELL_PORT_W'($urandom);
		s.red_value   = bds_pkg::VALUE_PORT_W'($urandom);
		s.green_value = bds_pkg::VALUE_PORT_W'($urandom);
		s.blue_value  = bds_pkg::VALUE_PORT_W'($urandom);
		s.pixel_x     = bds_pkg::PIXEL_PORT_W'($urandom);
		s.pixel_y     = bds_pkg::PIXEL_PORT_W'($urandom);
		s.gamma_index = bds_pkg::GIDX_PORT_W'($urandom);
		s.gamma_byte  = bds_pkg::LEVEL_W'($urandom);
		s.typed       = 1'b0;
		s.rgb         = '0;
		return s;
	endfunction

	function automatic sampler_op_t cell_op(input int x, y,
			input logic signed [bds_pkg::VALUE_PORT_W-1:0] r, g, b);
		sampler_op_t s;
		s             = scramble_op();
		s.command     = bds_pkg::CMD_WRITE_CELL;
		s.cell_x      = bds_pkg::CELL_PORT_W'(x);
		s.cell_y      = bds_pkg::CELL_PORT_W'(y);
		s.red_value   = r;
		s.green_value = g;
		s.blue_value  = b;
		return s;
	endfunction

	function automatic sampler_op_t sample_op(input int px, py, input bit typed = 1'b0,
			input logic [bds_pkg::RGB_W-1:0] rgb = '0);
		sampler_op_t s;
		s         = scramble_op();
		s.command = bds_pkg::CMD_SAMPLE;
		s.pixel_x = bds_pkg::PIXEL_PORT_W'(px);
		s.pixel_y = bds_pkg::PIXEL_PORT_W'(py);
		s.typed   = typed;
		s.rgb     = rgb;
		return s;
	endfunction

	function automatic sampler_op_t gamma_op(input int idx, lvl);
		sampler_op_t s;
		s             = scramble_op();
		s.command     = bds_pkg::CMD_WRITE_GAMMA;
		s.gamma_index = bds_pkg::GIDX_PORT_W'(idx);
		s.gamma_byte  = bds_pkg::LEVEL_W'(lvl);
		return s;
	endfunction

	function automatic sampler_op_t unused_op();
		sampler_op_t s;
		s         = scramble_op();
		s.command = CMD_UNUSED;
		return s;
	endfunction

	// Mostly near [0,1] so blends land inside the ramp; the rest anywhere
	function automatic logic signed [bds_pkg::VALUE_PORT_W-1:0] random_density();
		int v;
		if ($urandom_range(0, 9) < 7) begin
			v = int'($urandom_range(0, 20480)) - 2048;
			return v[bds_pkg::VALUE_PORT_W-1:0];
		end
		return bds_pkg::VALUE_PORT_W'($urandom);
	endfunction

	function automatic sampler_op_t random_op();
		int          pick;
		sampler_op_t s;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			// half the pixels near the origin so coarse scales still blend
			if ($urandom_range(0, 1) != 0)
				s = sample_op($urandom_range(0, 4095), $urandom_range(0, 4095));
			else
				s = sample_op($urandom_range(0, 160), $urandom_range(0, 160));
		end else if (pick < 80) begin
			// half the writes near the origin, where most samples land
			if ($urandom_range(0, 1) != 0)
				s = cell_op($urandom_range(0, 7), $urandom_range(0, 7),
					random_density(), random_density(), random_density());
			else
				s = cell_op($urandom_range(0, bds_pkg::GRID_ROOT + 1),
					$urandom_range(0, bds_pkg::GRID_ROOT + 1),
					random_density(), random_density(), random_density());
			// now and then aim past the grid; the block must drop it
			if ($urandom_range(0, 11) == 0) begin
				if ($urandom_range(0, 1) != 0)
					s.cell_x = bds_pkg::CELL_PORT_W'(
						$urandom_range(bds_pkg::GRID_ROOT + 2, 255));
				else
					s.cell_y = bds_pkg::CELL_PORT_W'(
						$urandom_range(bds_pkg::GRID_ROOT + 2, 255));
			end
		end else if (pick < 95) begin
			s = gamma_op($urandom_range(0, bds_pkg::GAMMA_ENTRIES - 1), $urandom_range(0, 255));
		end else begin
			s = unused_op();
		end
		return s;
	endfunction

	// ---------------------------------------------------------------------
	// Drivers: all called and returning at a falling edge
	// ---------------------------------------------------------------------

	// Present one item, optionally after an idle burst, and hold it until taken
	task automatic push_item(input sampler_op_t s);
		if (idle_on && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_valid    <= 1'b1;
		command     <= s.command;
		cell_x      <= s.cell_x;
		cell_y      <= s.cell_y;
		red_value   <= s.red_value;
		green_value <= s.green_value;
		blue_value  <= s.blue_value;
		pixel_x     <= s.pixel_x;
		pixel_y     <= s.pixel_y;
		gamma_index <= s.gamma_index;
		gamma_byte  <= s.gamma_byte;
		cur_typed   <= s.typed;
		cur_rgb     <= s.rgb;
		do
			@(posedge clk);
		while (!in_ready);
		sent_items++;
		@(negedge clk);
	endtask

	// Write every neighbour cell and gamma entry a sample would read unwritten, then send it
	task automatic push_sample(input sampler_op_t s);
		int                        x0, y0, ri, gi, bi;
		int                        gsel [3];
		logic [bds_pkg::WGT_W-1:0] fx, fy;
		map_axis(s.pixel_x, x_scale_now, x0, fx);
		map_axis(s.pixel_y, y_scale_now, y0, fy);
		for (int k = 0; k < 4; k++) begin
			if (!cell_seen[x0 + k[0] + bds_pkg::GRID_SIDE * (y0 + k[1])])
				push_item(cell_op(x0 + k[0], y0 + k[1],
					random_density(), random_density(), random_density()));
		end
		sample_indexes(s.pixel_x, s.pixel_y, ri, gi, bi);
		gsel = '{ri, gi, bi};
		foreach (gsel[k]) begin
			if (!level_seen[gsel[k]])
				push_item(gamma_op(gsel[k], $urandom_range(0, 255)));
		end
		push_item(s);
	endtask

	task automatic push_op(input sampler_op_t s);
		if (s.command == bds_pkg::CMD_SAMPLE)
			push_sample(s);
		else
			push_item(s);
	endtask

	// Pulse one register write; the strobe is high for a single cycle
	task automatic write_reg(input logic [bds_pkg::CFG_IDX_W-1:0] idx,
			input logic [bds_pkg::CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Drop valid, wait for every result, then let trailing writes leave the pipe
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_rgb.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Receiver: random stall bursts while idling is on, else always ready
	// ---------------------------------------------------------------------
	initial begin
		out_ready = 1'b0;
		@(negedge clk);
		forever begin
			if (idle_on && $urandom_range(0, 15) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
				@(negedge clk);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: check results, track register writes, advance the predictor
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		int                        slot;
		logic [bds_pkg::RGB_W-1:0] want;
		if (!arst_n) begin
			x_scale_now = bds_pkg::SCALE_RESET;
			y_scale_now = bds_pkg::SCALE_RESET;
		end else begin
			// Results first: anything leaving now belongs to an older item
			if (out_valid && out_ready) begin
				if (expected_rgb.size() == 0) begin
					$error("pixel_rgb: result %h with nothing expected", pixel_rgb);
					rgb_errors++;
				end else begin
					want = expected_rgb.pop_front();
					if (pixel_rgb !== want) begin
						$error("pixel_rgb: expected %h, actual %h", want, pixel_rgb);
						rgb_errors++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					bds_pkg::CFG_X_SCALE: x_scale_now = cfg_data;
					bds_pkg::CFG_Y_SCALE: y_scale_now = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				case (command)
					bds_pkg::CMD_WRITE_CELL: begin
						// drop writes outside the bordered grid
						if (cell_x <= bds_pkg::GRID_ROOT + 1
								&& cell_y <= bds_pkg::GRID_ROOT + 1) begin
							slot = cell_x + bds_pkg::GRID_SIDE * cell_y;
							density_grid[slot] = '{red_value, green_value, blue_value};
							cell_seen[slot]    = 1'b1;
						end
					end
					bds_pkg::CMD_WRITE_GAMMA: begin
						if (gamma_index < bds_pkg::GAMMA_ENTRIES) begin
							level_lut[gamma_index]  = gamma_byte;
							level_seen[gamma_index] = 1'b1;
						end
					end
					bds_pkg::CMD_SAMPLE: expected_rgb.push_back(cur_typed ? cur_rgb
						: predict_rgb(pixel_x, pixel_y));
					default: ;
				endcase
			end
		end
	end

	// Watchdog: end the run if no item, result or register write moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
			if (stuck_cycles >= WATCHDOG_LIMIT) begin
				$display("** bilinear_density_sampler_gamma: FAILED **");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	initial begin
		sampler_op_t                 directed_ops [$];
		logic [bds_pkg::SCALE_W-1:0] x_plan [NUM_PHASES];
		logic [bds_pkg::SCALE_W-1:0] y_plan [NUM_PHASES];
		int                          goal;

		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		command     = '0;
		cell_x      = '0;
		cell_y      = '0;
		red_value   = '0;
		green_value = '0;
		blue_value  = '0;
		pixel_x     = '0;
		pixel_y     = '0;
		gamma_index = '0;
		gamma_byte  = '0;
		cur_typed   = 1'b0;
		cur_rgb     = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table at unit scale: a pixel lands exactly on its cell.
		// Samples first write any entry they would read that is still unwritten.
		directed_ops = '{
			// pin both ends of the gamma table: clamped channels read 00 or FF
			gamma_op(bds_pkg::GAMMA_ENTRIES - 1, 8'hFF),
			gamma_op(0, 8'h00),
			// above one, most negative, exactly one
			cell_op(0, 0, 32767, -32768, 16384),
			sample_op(0, 0, 1'b1, 24'hFF00FF),
			// far corner cell, reached only through saturation in both axes
			cell_op(bds_pkg::GRID_ROOT + 1, bds_pkg::GRID_ROOT + 1, 0, 16384, -1),
			sample_op(4095, 4095, 1'b1, 24'h00FF00),
			// writes past the grid are dropped
			sample_op(5, 5),
			cell_op(bds_pkg::GRID_ROOT + 2, 5, 16384, 16384, 16384),
			cell_op(5, 255, -32768, -32768, -32768),
			cell_op(255, 255, 32767, 32767, 32767),
			sample_op(5, 5),
			// rewrite both ends of the gamma table and see them come back
			gamma_op(bds_pkg::GAMMA_ENTRIES - 1, 8'h5A),
			gamma_op(0, 8'hA5),
			sample_op(0, 0, 1'b1, 24'h5AA55A),
			unused_op(),
			// last cell that maps without saturation, and one past it
			cell_op(bds_pkg::GRID_ROOT, bds_pkg::GRID_ROOT, 8192, 100, -200),
			sample_op(bds_pkg::GRID_ROOT, bds_pkg::GRID_ROOT),
			sample_op(bds_pkg::GRID_ROOT + 1, 0),
			sample_op(0, bds_pkg::GRID_ROOT + 1),
			cell_op(64, 64, 16383, 1, 0),
			sample_op(64, 64),
			unused_op(),
			gamma_op(512, 8'hFF),
			gamma_op(511, 8'h00),
			sample_op(4095, 0),
			sample_op(64, 4095)
		};
		foreach (directed_ops[k])
			push_op(directed_ops[k]);
		settle();

		// Scale settings: both extremes, fine scales that spread pixels over the
		// grid with fractional weights, and coarse ones near unit scale
		x_plan[0] = '0;
		y_plan[0] = '0;
		x_plan[1] = '1;
		y_plan[1] = '1;
		x_plan[2] = bds_pkg::SCALE_W'($urandom_range(0, 2200));
		y_plan[2] = bds_pkg::SCALE_W'($urandom_range(0, 2200));
		x_plan[3] = bds_pkg::SCALE_W'($urandom_range(24'h8000, 24'h30000));
		y_plan[3] = bds_pkg::SCALE_W'($urandom_range(0, 2200));
		x_plan[4] = bds_pkg::SCALE_W'($urandom_range(0, 2200));
		y_plan[4] = bds_pkg::SCALE_W'($urandom_range(24'h8000, 24'h30000));
		x_plan[5] = bds_pkg::SCALE_W'($urandom_range(0, 2200));
		y_plan[5] = bds_pkg::SCALE_W'($urandom_range(0, 2200));

		for (int p = 0; p < NUM_PHASES; p++) begin
			// last phase runs at full rate on both sides
			idle_on = (p != NUM_PHASES - 1);
			write_reg(bds_pkg::CFG_X_SCALE, x_plan[p]);
			write_reg(bds_pkg::CFG_Y_SCALE, y_plan[p]);
			// writes to unmapped indexes must leave the scales alone
			if (p == 2) begin
				write_reg(CFG_SPARE_LO, bds_pkg::CFG_DATA_W'($urandom));
				write_reg(CFG_SPARE_HI, bds_pkg::CFG_DATA_W'($urandom));
			end
			goal = sent_items + RANDOM_PER_PHASE;
			while (sent_items < goal)
				push_op(random_op());
			settle();
		end

		if (rgb_errors == 0)
			$display("** bilinear_density_sampler_gamma: PASSED **");
		else
			$display("** bilinear_density_sampler_gamma: FAILED **");
		$finish;
	end

endmodule
